>>> design/dpt_pkg.sv
// Shared types and constants of the demand page translator.
// Depends on nothing; every other file imports it.
package dpt_pkg;

  localparam int unsigned AddrW      = 32;
  localparam int unsigned MapW       = 8;
  localparam int unsigned ShiftW     = 5;
  localparam int unsigned ShiftMin   = 10;
  localparam int unsigned ShiftMax   = 20;
  localparam int unsigned ShiftReset = 12;
  localparam int unsigned HashMul    = 23;
  localparam int unsigned MulW       = 13;
  localparam int unsigned PageNumW   = AddrW - ShiftMin;
  localparam int unsigned SumW       = PageNumW + 1;

  typedef struct packed {
    logic             func;
    logic [MapW-1:0]  map_id;
    logic [AddrW-1:0] address;
  } dpt_in_t;

  typedef struct packed {
    logic [AddrW-1:0] phys_addr;
    logic             was_present;
    logic             ok;
    logic             full_res;
  } dpt_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_HEAD,
    ST_WALK,
    ST_ALLOC,
    ST_DONE
  } dpt_state_e;

  typedef struct packed {
    logic accept;
    logic head_rd;
    logic ent_rd_head;
    logic ent_rd_next;
    logic alloc;
    logic mark_found;
    logic out_load;
    logic clr_wr;
  } dpt_cmd_t;

  typedef struct packed {
    logic in_func;
    logic hash_done;
    logic head_valid;
    logic ent_match;
    logic ent_has_next;
    logic out_stall;
    logic clr_last;
  } dpt_sts_t;

endpackage

>>> design/dpt_in_if.sv
// Input channel of the translator: valid, ready and one request item.
// Depends on dpt_pkg.
interface dpt_in_if import dpt_pkg::*; ();
  logic    valid;
  logic    ready;
  dpt_in_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> design/dpt_out_if.sv
// Output channel of the translator: valid, ready and one result item.
// Depends on dpt_pkg.
interface dpt_out_if import dpt_pkg::*; ();
  logic     valid;
  logic     ready;
  dpt_out_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> design/dpt_hash.sv
// Bucket index unit: (page number + map id * 23) mod HASH_BUCKETS.
// Power-of-two bucket counts take a mask, others a reciprocal multiply and one correction.
// Depends on dpt_pkg.
module dpt_hash import dpt_pkg::*; #(
  parameter int unsigned HASH_BUCKETS = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [SumW-1:0]                 sum_i,
  output logic                            done_o,
  output logic [$clog2(HASH_BUCKETS)-1:0] bucket_o
);

  localparam int unsigned BW     = $clog2(HASH_BUCKETS);
  localparam bit          IsPow2 = (HASH_BUCKETS & (HASH_BUCKETS - 1)) == 0;

  if (IsPow2) begin : g_mask
    logic [BW-1:0] bucket_q;

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        bucket_q <= sum_i[BW-1:0];
      end
    end

    assign bucket_o = bucket_q;
    assign done_o   = 1'b1;
  end else begin : g_recip
    localparam int unsigned     RecK = SumW + BW;
    localparam int unsigned     RecW = SumW + 1;
    localparam logic [RecW-1:0] RecM = RecW'((64'd1 << RecK) / 64'(HASH_BUCKETS));
    localparam logic [SumW-1:0] Div  = SumW'(HASH_BUCKETS);

    logic [SumW-1:0]      sum_q;
    logic [SumW-1:0]      quo_q;
    logic [BW-1:0]        rem_q;
    logic [1:0]           phase_q;
    logic [SumW+RecW-1:0] prod;
    logic [SumW-1:0]      quo_mul;
    logic [SumW-1:0]      diff;

    // Quotient estimate is exact or one low; one subtract fixes the remainder
    assign prod    = (SumW+RecW)'(sum_q) * (SumW+RecW)'(RecM);
    assign quo_mul = quo_q * Div;
    assign diff    = sum_q - quo_mul;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        phase_q <= '0;
      end else if (start_i) begin
        phase_q <= 2'd2;
      end else if (phase_q != '0) begin
        phase_q <= phase_q - 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        sum_q <= sum_i;
      end
      if (phase_q == 2'd2) begin
        quo_q <= SumW'(prod >> RecK);
      end
      if (phase_q == 2'd1) begin
        rem_q <= (diff >= Div) ? BW'(diff - Div) : BW'(diff);
      end
    end

    assign bucket_o = rem_q;
    assign done_o   = (phase_q == '0);
  end

endmodule

>>> design/dpt_ctrl.sv
// Controller of the translator: sequences clearing, hashing, chain walk,
// allocation and result load. Depends on dpt_pkg.
module dpt_ctrl import dpt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dpt_sts_t sts_i,
  output dpt_cmd_t cmd_o
);

  dpt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = sts_i.in_func ? ST_DONE : ST_HASH;
        end
      end
      ST_HASH: begin
        if (sts_i.hash_done) begin
          cmd_o.head_rd = 1'b1;
          state_d       = ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (sts_i.head_valid) begin
          cmd_o.ent_rd_head = 1'b1;
          state_d           = ST_WALK;
        end else begin
          state_d = ST_ALLOC;
        end
      end
      ST_WALK: begin
        if (sts_i.ent_match) begin
          cmd_o.mark_found = 1'b1;
          state_d          = ST_DONE;
        end else if (sts_i.ent_has_next) begin
          cmd_o.ent_rd_next = 1'b1;
        end else begin
          state_d = ST_ALLOC;
        end
      end
      ST_ALLOC: begin
        cmd_o.alloc = 1'b1;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        if (!sts_i.out_stall) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/dpt_datapath.sv
// Datapath of the translator: page shift register, bucket head and entry
// memories, page counter and output register. Depends on dpt_pkg and dpt_hash.
module dpt_datapath import dpt_pkg::*; #(
  parameter int unsigned MAX_PAGES    = 1024,
  parameter int unsigned HASH_BUCKETS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ShiftW-1:0] cfg_wdata_i,
  input  dpt_in_t           in_data_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output dpt_out_t          out_data_o,
  input  dpt_cmd_t          cmd_i,
  output dpt_sts_t          sts_o
);

  localparam int unsigned BW   = $clog2(HASH_BUCKETS);
  localparam int unsigned PW   = $clog2(MAX_PAGES);
  localparam int unsigned CW   = $clog2(MAX_PAGES + 1);
  localparam int unsigned EntW = PageNumW + MapW + 1 + PW;

  logic [ShiftW-1:0] shift_q;
  logic [ShiftW-1:0] eff_sh;
  logic [AddrW-1:0]  mask;

  logic             func_q;
  logic [MapW-1:0]  mid_q;
  logic [AddrW-1:0] addr_q;

  logic [AddrW-1:0] in_shr;
  logic [MulW-1:0]  mid_mul;
  logic [SumW-1:0]  sum;
  logic [BW-1:0]    bucket;

  logic [PW:0]      head_mem [HASH_BUCKETS];
  logic [PW:0]      head_rdata_q;
  logic [BW-1:0]    clr_cnt_q;

  logic [EntW-1:0]  ent_mem [MAX_PAGES];
  logic [EntW-1:0]  ent_rdata_q;
  logic [EntW-1:0]  ent_wdata;
  logic [PW-1:0]    ent_raddr;
  logic [PW-1:0]    cur_q;

  logic [CW-1:0]    pages_used_q;
  logic [PW-1:0]    new_idx;
  logic             table_full;

  logic [PW-1:0]    idx_q;
  logic             present_q;
  logic             ok_q;
  logic             full_q;

  logic [AddrW-1:0] tag_cur;
  logic [AddrW-1:0] addr_shr;
  logic             check_ok;
  dpt_out_t         result;
  logic             out_valid_q;
  dpt_out_t         out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= ShiftW'(ShiftReset);
    end else if (cfg_we_i) begin
      shift_q <= cfg_wdata_i;
    end
  end

  assign eff_sh = (shift_q < ShiftW'(ShiftMin)) ? ShiftW'(ShiftMin) :
                  (shift_q > ShiftW'(ShiftMax)) ? ShiftW'(ShiftMax) : shift_q;
  assign mask   = (AddrW'(1) << eff_sh) - AddrW'(1);

  // Bucket sum formed from the incoming item at the transfer
  assign in_shr  = in_data_i.address >> eff_sh;
  assign mid_mul = MulW'(in_data_i.map_id) * MulW'(HashMul);
  assign sum     = SumW'(in_shr[PageNumW-1:0]) + SumW'(mid_mul);

  dpt_hash #(
    .HASH_BUCKETS(HASH_BUCKETS)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.accept),
    .sum_i   (sum),
    .done_o  (sts_o.hash_done),
    .bucket_o(bucket)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q <= in_data_i.func;
      mid_q  <= in_data_i.map_id;
      addr_q <= in_data_i.address;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  assign table_full = (pages_used_q == CW'(MAX_PAGES));
  assign new_idx    = pages_used_q[PW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      head_mem[clr_cnt_q] <= '0;
    end else if (cmd_i.alloc && !table_full) begin
      head_mem[bucket] <= {1'b1, new_idx};
    end
    if (cmd_i.head_rd) begin
      head_rdata_q <= head_mem[bucket];
    end
  end

  assign tag_cur   = addr_q & ~mask;
  assign ent_wdata = {tag_cur[AddrW-1 -: PageNumW], mid_q, head_rdata_q[PW],
                      head_rdata_q[PW-1:0]};
  assign ent_raddr = cmd_i.ent_rd_head ? head_rdata_q[PW-1:0] : ent_rdata_q[PW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc && !table_full) begin
      ent_mem[new_idx] <= ent_wdata;
    end
    if (cmd_i.ent_rd_head || cmd_i.ent_rd_next) begin
      ent_rdata_q <= ent_mem[ent_raddr];
      cur_q       <= ent_raddr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pages_used_q <= '0;
    end else if (cmd_i.alloc && !table_full) begin
      pages_used_q <= pages_used_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      present_q <= 1'b0;
      ok_q      <= 1'b0;
      full_q    <= 1'b0;
    end else if (cmd_i.mark_found) begin
      present_q <= 1'b1;
      ok_q      <= 1'b1;
      idx_q     <= cur_q;
    end else if (cmd_i.alloc) begin
      if (table_full) begin
        full_q <= 1'b1;
      end else begin
        ok_q  <= 1'b1;
        idx_q <= new_idx;
      end
    end
  end

  assign addr_shr = addr_q >> eff_sh;
  assign check_ok = addr_shr < AddrW'(pages_used_q);

  always_comb begin
    result = '0;
    if (func_q) begin
      result.ok = check_ok;
    end else begin
      result.was_present = present_q;
      result.ok          = ok_q;
      result.full_res    = full_q;
      if (ok_q) begin
        result.phys_addr = (AddrW'(idx_q) << eff_sh) | (addr_q & mask);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign sts_o.in_func      = in_data_i.func;
  assign sts_o.head_valid   = head_rdata_q[PW];
  assign sts_o.ent_match    = (ent_rdata_q[EntW-1 -: PageNumW] == tag_cur[AddrW-1 -: PageNumW])
                              && (ent_rdata_q[PW+1 +: MapW] == mid_q);
  assign sts_o.ent_has_next = ent_rdata_q[PW];
  assign sts_o.out_stall    = out_valid_q && !out_ready_i;
  assign sts_o.clr_last     = (clr_cnt_q == BW'(HASH_BUCKETS - 1));

endmodule

>>> design/demand_page_translator.sv
// Top level of the demand page translator: hashed page table with
// allocate-on-first-touch. Depends on dpt_pkg, dpt_in_if, dpt_out_if,
// dpt_ctrl and dpt_datapath.
//   in_i carries {func, map_id, address}; out_o returns one result per item,
//   {phys_addr, was_present, ok, full_res}, in request order. Both channels
//   transfer on valid && ready. cfg_we_i writes page_shift (reset 12); write
//   it only while no request is in flight.
//   One item is worked at a time. After the input transfer, a validity check
//   goes from the idle state to the done state and loads the output register.
//   A translate hashes the page number (a mask when HASH_BUCKETS is a power
//   of two, a reciprocal reduction otherwise), reads the bucket head, walks
//   the chain until a match, allocates on a miss (or sets full_res when the
//   table is full) and loads the result. The next item is taken in the
//   cycle after the result is loaded.
//   After reset the bucket head memory is cleared, one bucket per cycle, until
//   every bucket is written; in_i.ready stays low during that pass.
//   A stalled receiver holds the result in the output register; the next
//   item is still taken and worked, and waits to load until the register
//   frees.
module demand_page_translator import dpt_pkg::*; #(
  parameter int unsigned MAX_PAGES    = 1024,
  parameter int unsigned HASH_BUCKETS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ShiftW-1:0] cfg_wdata_i,
  dpt_in_if.sink            in_i,
  dpt_out_if.source         out_o
);

  dpt_cmd_t cmd;
  dpt_sts_t sts;

  dpt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_i.ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  dpt_datapath #(
    .MAX_PAGES   (MAX_PAGES),
    .HASH_BUCKETS(HASH_BUCKETS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_data_i  (in_i.data),
    .out_ready_i(out_o.ready),
    .out_valid_o(out_o.valid),
    .out_data_o (out_o.data),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule
